/* hdl/pngcsp_pkg.sv */
// Shared types and constants for the PNG chunk stream parser.
package pngcsp_pkg;

    // Parse phase, one-hot.
    typedef enum logic [7:0] {
        PH_SIG      = 8'b0000_0001,
        PH_HDR      = 8'b0000_0010,
        PH_LEN      = 8'b0000_0100,
        PH_TYPE     = 8'b0000_1000,
        PH_BODY     = 8'b0001_0000,
        PH_CRC      = 8'b0010_0000,
        PH_IEND_CRC = 8'b0100_0000,
        PH_IGNORE   = 8'b1000_0000
    } t_phase;

    // Byte class labels.
    localparam logic [3:0] KIND_SIG      = 4'd0;
    localparam logic [3:0] KIND_HDR      = 4'd1;
    localparam logic [3:0] KIND_LEN      = 4'd2;
    localparam logic [3:0] KIND_TYPE     = 4'd3;
    localparam logic [3:0] KIND_IDAT     = 4'd4;
    localparam logic [3:0] KIND_IDAT_CRC = 4'd5;
    localparam logic [3:0] KIND_OTHER    = 4'd6;
    localparam logic [3:0] KIND_IEND     = 4'd7;
    localparam logic [3:0] KIND_IGNORED  = 4'd8;

    // End-of-stream status codes.
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_SHORT_SIG = 2'd1;
    localparam logic [1:0] STAT_SHORT_HDR = 2'd2;
    localparam logic [1:0] STAT_TRUNC     = 2'd3;

    // Fixed stream prefix sizes and chunk type codes.
    localparam logic [5:0]  SIG_BYTES = 6'd8;
    localparam logic [5:0]  HDR_BYTES = 6'd25;
    localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    // One result beat.
    typedef struct packed {
        logic [7:0] byte_value;
        logic [3:0] byte_kind;
        logic       idat_end;
        logic       stream_done;
        logic [1:0] status;
    } t_result;

endpackage

/* hdl/pngcsp_in_reg.sv */
// Input register stage of the PNG chunk stream parser.
module pngcsp_in_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  pngcsp_pkg::t_beat    i_beat,
    output logic                 o_stall,
    input  logic                 i_advance,
    output logic                 o_valid,
    output pngcsp_pkg::t_beat    o_beat
);

    logic              r_valid;
    pngcsp_pkg::t_beat r_beat;

    // Hold the beat while the next stage cannot take it.
    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Payload capture needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_beat <= i_beat;
        end
    end

endmodule

/* hdl/pngcsp_step.sv */
// Parse state and per-byte classification of the PNG chunk stream parser.
module pngcsp_step (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  pngcsp_pkg::t_beat     i_beat,
    output pngcsp_pkg::t_result   o_result
);

    pngcsp_pkg::t_phase r_phase, n_phase;
    logic [5:0]         r_prefix, n_prefix;
    logic [1:0]         r_field, n_field;
    logic [31:0]        r_len, n_len;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_type, n_type;
    logic               r_idat, n_idat;

    logic [5:0] prefix_inc;
    logic [1:0] field_inc;
    logic [3:0] kind;
    logic       idat_end;
    logic [1:0] status;

    assign prefix_inc = r_prefix + 6'd1;
    assign field_inc  = r_field + 2'd1;

    // Next state and byte label for the beat in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_prefix = r_prefix;
        n_field  = r_field;
        n_len    = r_len;
        n_rem    = r_rem;
        n_type   = r_type;
        n_idat   = r_idat;
        kind     = pngcsp_pkg::KIND_IGNORED;
        idat_end = 1'b0;
        case (r_phase)
            pngcsp_pkg::PH_SIG: begin
                kind     = pngcsp_pkg::KIND_SIG;
                n_prefix = prefix_inc;
                if (prefix_inc >= pngcsp_pkg::SIG_BYTES) begin
                    n_phase  = pngcsp_pkg::PH_HDR;
                    n_prefix = 6'd0;
                end
            end
            pngcsp_pkg::PH_HDR: begin
                kind     = pngcsp_pkg::KIND_HDR;
                n_prefix = prefix_inc;
                if (prefix_inc >= pngcsp_pkg::HDR_BYTES) begin
                    n_phase  = pngcsp_pkg::PH_LEN;
                    n_prefix = 6'd0;
                    n_field  = 2'd0;
                end
            end
            pngcsp_pkg::PH_LEN: begin
                kind    = pngcsp_pkg::KIND_LEN;
                n_len   = {r_len[23:0], i_beat.data_byte};
                n_field = field_inc;
                if (field_inc == 2'd0) begin
                    n_phase = pngcsp_pkg::PH_TYPE;
                    n_rem   = n_len;
                end
            end
            pngcsp_pkg::PH_TYPE: begin
                kind    = pngcsp_pkg::KIND_TYPE;
                n_type  = {r_type[23:0], i_beat.data_byte};
                n_field = field_inc;
                if (field_inc == 2'd0) begin
                    if (n_type == pngcsp_pkg::TYPE_IEND) begin
                        n_idat  = 1'b0;
                        n_phase = pngcsp_pkg::PH_IEND_CRC;
                    end else begin
                        n_idat  = (n_type == pngcsp_pkg::TYPE_IDAT);
                        n_phase = (r_rem == 32'd0) ? pngcsp_pkg::PH_CRC
                                                   : pngcsp_pkg::PH_BODY;
                    end
                end
            end
            pngcsp_pkg::PH_BODY: begin
                kind  = r_idat ? pngcsp_pkg::KIND_IDAT : pngcsp_pkg::KIND_OTHER;
                n_rem = r_rem - 32'd1;
                if (n_rem == 32'd0) begin
                    idat_end = r_idat;
                    n_phase  = pngcsp_pkg::PH_CRC;
                    n_field  = 2'd0;
                end
            end
            pngcsp_pkg::PH_CRC: begin
                kind    = r_idat ? pngcsp_pkg::KIND_IDAT_CRC : pngcsp_pkg::KIND_OTHER;
                n_field = field_inc;
                if (field_inc == 2'd0) begin
                    n_phase = pngcsp_pkg::PH_LEN;
                    n_idat  = 1'b0;
                end
            end
            pngcsp_pkg::PH_IEND_CRC: begin
                kind    = pngcsp_pkg::KIND_IEND;
                n_field = field_inc;
                if (field_inc == 2'd0) begin
                    n_phase = pngcsp_pkg::PH_IGNORE;
                end
            end
            default: begin
                kind = pngcsp_pkg::KIND_IGNORED;
            end
        endcase
    end

    // Status on the final byte comes from where parsing stands after it.
    always_comb begin
        status = pngcsp_pkg::STAT_OK;
        if (i_beat.last_byte) begin
            case (n_phase)
                pngcsp_pkg::PH_SIG:    status = pngcsp_pkg::STAT_SHORT_SIG;
                pngcsp_pkg::PH_HDR:    status = pngcsp_pkg::STAT_SHORT_HDR;
                pngcsp_pkg::PH_IGNORE: status = pngcsp_pkg::STAT_OK;
                pngcsp_pkg::PH_LEN: begin
                    status = (n_field == 2'd0) ? pngcsp_pkg::STAT_OK
                                               : pngcsp_pkg::STAT_TRUNC;
                end
                default:               status = pngcsp_pkg::STAT_TRUNC;
            endcase
        end
    end

    assign o_result.byte_value  = i_beat.data_byte;
    assign o_result.byte_kind   = kind;
    assign o_result.idat_end    = idat_end;
    assign o_result.stream_done = i_beat.last_byte;
    assign o_result.status      = status;

    // Control state; the final byte returns the parser to its start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pngcsp_pkg::PH_SIG;
            r_prefix <= 6'd0;
            r_field  <= 2'd0;
            r_idat   <= 1'b0;
        end else if (i_fire) begin
            if (i_beat.last_byte) begin
                r_phase  <= pngcsp_pkg::PH_SIG;
                r_prefix <= 6'd0;
                r_field  <= 2'd0;
                r_idat   <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_prefix <= n_prefix;
                r_field  <= n_field;
                r_idat   <= n_idat;
            end
        end
    end

    // Length, remaining count and type are always loaded before use.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_len  <= n_len;
            r_rem  <= n_rem;
            r_type <= n_type;
        end
    end

endmodule

/* hdl/pngcsp_out_reg.sv */
// Result register stage of the PNG chunk stream parser.
module pngcsp_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  pngcsp_pkg::t_result   i_result,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pngcsp_pkg::t_result   o_result
);

    logic                r_valid;
    pngcsp_pkg::t_result r_result;

    // A new result may enter when the register is empty or being drained.
    assign o_ready  = !(r_valid && i_stall);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* hdl/png_chunk_stream_parser_unit.sv */
// Top level of the PNG chunk stream parser.
//
// Takes a PNG stream one byte per beat and returns one labelled result beat
// per input beat, in order. Throughput is one byte per clock while the
// output is not stalled. Each beat passes through the input register, then
// the result register. The per-byte path is the phase update and the 32-bit
// chunk length down-counter with its zero test, done combinationally between
// the two registers. The parser returns to its start state after the beat
// flagged as last.
module png_chunk_stream_parser_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_byte_value,
    output logic [3:0] o_byte_kind,
    output logic       o_idat_end,
    output logic       o_stream_done,
    output logic [1:0] o_status
);

    pngcsp_pkg::t_beat   in_beat;
    pngcsp_pkg::t_beat   held_beat;
    pngcsp_pkg::t_result step_result;
    pngcsp_pkg::t_result out_result;
    logic                held_valid;
    logic                out_ready;
    logic                fire;

    assign in_beat.data_byte = i_data_byte;
    assign in_beat.last_byte = i_last_byte;

    // A held beat moves on whenever the result register can take it.
    assign fire = held_valid && out_ready;

    pngcsp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_beat    (in_beat),
        .o_stall   (o_stall),
        .i_advance (out_ready),
        .o_valid   (held_valid),
        .o_beat    (held_beat)
    );

    pngcsp_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_beat   (held_beat),
        .o_result (step_result)
    );

    pngcsp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire),
        .i_result (step_result),
        .o_ready  (out_ready),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (out_result)
    );

    assign o_byte_value  = out_result.byte_value;
    assign o_byte_kind   = out_result.byte_kind;
    assign o_idat_end    = out_result.idat_end;
    assign o_stream_done = out_result.stream_done;
    assign o_status      = out_result.status;

endmodule
